[hdl/assert_macros.svh]
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, skipped while reset is asserted.
`define CSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define CSS_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[hdl/css_pkg.sv]
// Shared constants and controller/datapath interface types of the sort engine.
package css_pkg;

  localparam int MaxKeysDef = 64;
  localparam int KeyBitsDef = 16;
  localparam int KeyPortW   = 16;

  // Controller to datapath commands, at most one set per cycle.
  typedef struct packed {
    logic load;     // accept input request, store key
    logic first;    // issue first read of a pass
    logic prime;    // capture carried key, issue second read
    logic step;     // compare, write back, advance
    logic flush;    // write carried key, narrow range, flip direction
    logic emit_rd;  // read next sorted key
    logic emit_ld;  // load output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic range_small;  // fewer than two keys left unsorted
    logic step_last;    // current step consumes the last key of the pass
    logic emit_last;    // key being emitted is the last of the set
    logic out_free;     // output register can take a new result
  } sts_t;

endpackage

[hdl/css_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module css_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/css_ctrl.sv]
// Sequencing state machine of the sort engine: load, sort passes, emission.
module css_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          set_end_i,
  input  css_pkg::sts_t sts_i,
  output css_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StChk    = 3'd1;
  localparam logic [2:0] StFirst  = 3'd2;
  localparam logic [2:0] StPrime  = 3'd3;
  localparam logic [2:0] StStep   = 3'd4;
  localparam logic [2:0] StFlush  = 3'd5;
  localparam logic [2:0] StEmitRd = 3'd6;
  localparam logic [2:0] StEmitLd = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i && set_end_i) begin
          state_d = StChk;
        end
      end
      StChk: begin
        state_d = sts_i.range_small ? StEmitRd : StFirst;
      end
      StFirst: begin
        cmd_o.first = 1'b1;
        state_d     = StPrime;
      end
      StPrime: begin
        cmd_o.prime = 1'b1;
        state_d     = StStep;
      end
      StStep: begin
        cmd_o.step = 1'b1;
        if (sts_i.step_last) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        cmd_o.flush = 1'b1;
        state_d     = StChk;
      end
      StEmitRd: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = StEmitLd;
      end
      StEmitLd: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          state_d       = sts_i.emit_last ? StIdle : StEmitRd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

[hdl/css_dp.sv]
// Datapath of the sort engine: key store, pass bounds, carry register, output register.
module css_dp #(
  parameter int MaxKeys = css_pkg::MaxKeysDef,
  parameter int KeyBits = css_pkg::KeyBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  css_pkg::cmd_t                cmd_i,
  output css_pkg::sts_t                sts_o,
  input  logic [css_pkg::KeyPortW-1:0] key_in_i,
  input  logic                         set_end_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [css_pkg::KeyPortW-1:0] key_out_o,
  output logic                         run_end_o,
  output logic                         dropped_o
);

  localparam int AW = $clog2(MaxKeys);
  localparam int CW = $clog2(MaxKeys + 1);
  localparam int PW = css_pkg::KeyPortW;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic          fwd_q, fwd_d;
  logic [CW-1:0] ptr_q, ptr_d, wptr_q, wptr_d, cnt_q, cnt_d, k_q, k_d;
  logic [KeyBits-1:0] carry_q, carry_d;
  logic          out_valid_q, out_valid_d;
  logic [PW-1:0] key_out_q, key_out_d;
  logic          run_end_q, run_end_d, dropped_q, dropped_d;

  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [KeyBits-1:0] wdata, rdata;

  logic [KeyBits+PW-1:0] key_in_wide, key_rd_wide;
  logic [KeyBits-1:0]    key_ld;
  logic [CW-1:0]         first_addr;
  logic                  full, gt, emit_last;

  css_ram #(
    .Width(KeyBits),
    .Depth(MaxKeys)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Key kept at KeyBits; result port carries the low port bits.
  assign key_in_wide = {KeyBits'(0), key_in_i};
  assign key_ld      = key_in_wide[KeyBits-1:0];
  assign key_rd_wide = {PW'(0), rdata};

  assign full       = (count_q == CW'(MaxKeys));
  assign first_addr = fwd_q ? lo_q : hi_q - CW'(1);
  assign gt         = (carry_q > rdata);
  assign emit_last  = ((k_q + CW'(1)) == count_q);

  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    fwd_d       = fwd_q;
    ptr_d       = ptr_q;
    wptr_d      = wptr_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    carry_d     = carry_q;
    key_out_d   = key_out_q;
    run_end_d   = run_end_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = count_q[AW-1:0];
    wdata       = key_ld;
    raddr       = ptr_q[AW-1:0];

    if (cmd_i.load) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        we      = 1'b1;
        count_d = count_q + CW'(1);
      end
      if (set_end_i) begin
        lo_d  = '0;
        hi_d  = full ? count_q : count_q + CW'(1);
        fwd_d = 1'b1;
        k_d   = '0;
      end
    end

    if (cmd_i.first) begin
      re     = 1'b1;
      raddr  = first_addr[AW-1:0];
      wptr_d = first_addr;
      ptr_d  = fwd_q ? lo_q + CW'(1) : hi_q - CW'(2);
      cnt_d  = hi_q - lo_q - CW'(1);
    end

    if (cmd_i.prime) begin
      carry_d = rdata;
      re      = 1'b1;
      ptr_d   = fwd_q ? ptr_q + CW'(1) : ptr_q - CW'(1);
    end

    if (cmd_i.step) begin
      // forward keeps the larger key moving up, backward the smaller down
      we    = 1'b1;
      waddr = wptr_q[AW-1:0];
      if (fwd_q) begin
        wdata   = gt ? rdata : carry_q;
        carry_d = gt ? carry_q : rdata;
        wptr_d  = wptr_q + CW'(1);
      end else begin
        wdata   = gt ? carry_q : rdata;
        carry_d = gt ? rdata : carry_q;
        wptr_d  = wptr_q - CW'(1);
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q != CW'(1)) begin
        re    = 1'b1;
        ptr_d = fwd_q ? ptr_q + CW'(1) : ptr_q - CW'(1);
      end
    end

    if (cmd_i.flush) begin
      we    = 1'b1;
      waddr = wptr_q[AW-1:0];
      wdata = carry_q;
      if (fwd_q) begin
        hi_d = hi_q - CW'(1);
      end else begin
        lo_d = lo_q + CW'(1);
      end
      fwd_d = !fwd_q;
    end

    if (cmd_i.emit_rd) begin
      re    = 1'b1;
      raddr = k_q[AW-1:0];
    end

    if (cmd_i.emit_ld) begin
      out_valid_d = 1'b1;
      key_out_d   = key_rd_wide[PW-1:0];
      run_end_d   = emit_last;
      dropped_d   = ovf_q;
      k_d         = k_q + CW'(1);
      if (emit_last) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      fwd_q       <= 1'b1;
      ptr_q       <= '0;
      wptr_q      <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      fwd_q       <= fwd_d;
      ptr_q       <= ptr_d;
      wptr_q      <= wptr_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q   <= carry_d;
    key_out_q <= key_out_d;
    run_end_q <= run_end_d;
    dropped_q <= dropped_d;
  end

  assign sts_o.range_small = ((hi_q - lo_q) < CW'(2));
  assign sts_o.step_last   = (cnt_q == CW'(1));
  assign sts_o.emit_last   = emit_last;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign key_out_o   = key_out_q;
  assign run_end_o   = run_end_q;
  assign dropped_o   = dropped_q;

endmodule

[hdl/cocktail_shaker_sort_engine.sv]
// Bidirectional bubble sort engine: collects a key set, sorts it in RAM, emits it in order.
// Load: one key request per cycle while idle; each accepted key is stored until the store is full.
// Sort: a pass checks the range, issues the first read, primes the carry and then steps
//   (one RAM read and one write a cycle), then writes the carry and flips direction.
// Emit: each result is a store read, then an output register load once the register is free.
// Reset clears control, counts and the output valid; store contents stay undefined, no sweep.
module cocktail_shaker_sort_engine #(
  parameter int MaxKeys = css_pkg::MaxKeysDef,
  parameter int KeyBits = css_pkg::KeyBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input requests
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [css_pkg::KeyPortW-1:0] key_in_i,
  input  logic                         set_end_i,
  // result requests
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [css_pkg::KeyPortW-1:0] key_out_o,
  output logic                         run_end_o,
  output logic                         dropped_o
);

  css_pkg::cmd_t cmd;
  css_pkg::sts_t sts;

  // Controller: idle/load, pass sequencing, emission handshake.
  css_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .set_end_i (set_end_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_stall_o(in_stall_o)
  );

  // Datapath: key store RAM, range bounds, carry compare, output register.
  // The output register decouples the sink, so a new set is taken while the
  // last result of the previous one still waits.
  css_dp #(
    .MaxKeys(MaxKeys),
    .KeyBits(KeyBits)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .key_in_i   (key_in_i),
    .set_end_i  (set_end_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .key_out_o  (key_out_o),
    .run_end_o  (run_end_o),
    .dropped_o  (dropped_o)
  );

endmodule

[hdl/css_chk.sv]
// Port-level checker for the sort engine, bound to the top level.
`include "assert_macros.svh"

module css_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         set_end_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [css_pkg::KeyPortW-1:0] key_out_o,
  input logic                         run_end_o,
  input logic                         dropped_o
);

  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // a closing request starts the sort, so no request is taken next cycle
  `CSS_ASSERT(a_busy_after_end, clk_i, rst_ni, (in_acc && set_end_i) |=> in_stall_o, "request taken right after set end")
  // mid-run results only while input is held off
  `CSS_NEVER(a_no_load_mid_run, clk_i, rst_ni, out_acc && !run_end_o && !in_stall_o, "input open during emission")
  // stalled result holds
  `CSS_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(key_out_o) && $stable(run_end_o) && $stable(dropped_o)), "stalled result changed")

endmodule

bind cocktail_shaker_sort_engine css_chk u_css_chk (.*);

[test/tb.sv]
// Testbench for the cocktail shaker sort engine: random key sets, scoreboard of sorted results.
`timescale 1ns / 100ps

module tb;

  localparam int KeyW       = css_pkg::KeyPortW;
  localparam int Cap        = css_pkg::MaxKeysDef;
  localparam int ItemTarget = 430;
  localparam int CycleLimit = 400000;
  localparam int HoldStart  = 4000;   // sink clock at which the long hold-off begins
  localparam int HoldCycles = 3000;
  localparam int DrainWait  = 200;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            last;
  } key_req_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            run_end;
    logic            dropped;
  } sorted_key_t;

  typedef enum logic [1:0] {SinkFree, SinkLight, SinkHeavy, SinkToggle} sink_mode_e;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  logic [KeyW-1:0] key_in_i    = '0;
  logic            set_end_i   = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [KeyW-1:0] key_out_o;
  logic            run_end_o;
  logic            dropped_o;

  key_req_t    key_feed_q[$];
  sorted_key_t sorted_q[$];

  // model of the engine's store
  logic [KeyW-1:0] held_keys[Cap];
  int              held_cnt  = 0;
  logic            keys_lost = 1'b0;

  int errors     = 0;
  int burst_left = 0;
  int gap_left   = 0;
  int cycle_cnt  = 0;

  cocktail_shaker_sort_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .key_in_i    (key_in_i),
    .set_end_i   (set_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .key_out_o   (key_out_o),
    .run_end_o   (run_end_o),
    .dropped_o   (dropped_o)
  );

  always #1 clk_i = ~clk_i;

  // compare-swap of one neighbor pair
  task automatic order_pair(input int idx);
    logic [KeyW-1:0] t;
    if (held_keys[idx] > held_keys[idx + 1]) begin
      t                  = held_keys[idx];
      held_keys[idx]     = held_keys[idx + 1];
      held_keys[idx + 1] = t;
    end
  endtask

  // alternating passes: forward sinks the max to hi, backward lifts the min to lo
  task automatic shaker_sort(input int n);
    int lo, hi, pass, i;
    lo = 0;
    hi = n;
    for (pass = 0; pass < n; pass++) begin
      if (hi - lo < 2) break;
      if (pass % 2 == 0) begin
        for (i = lo; i + 1 < hi; i++) order_pair(i);
        hi--;
      end else begin
        for (i = hi - 1; i > lo; i--) order_pair(i - 1);
        lo++;
      end
    end
  endtask

  // store one accepted key; on end of set, sort and queue the whole sorted run
  task automatic collect_key(input logic [KeyW-1:0] key, input logic last);
    sorted_key_t r;
    int k;
    if (held_cnt < Cap) begin
      held_keys[held_cnt] = key;
      held_cnt++;
    end else begin
      keys_lost = 1'b1;
    end
    if (last) begin
      shaker_sort(held_cnt);
      for (k = 0; k < held_cnt; k++) begin
        r.key     = held_keys[k];
        r.run_end = (k + 1 == held_cnt);
        r.dropped = keys_lost;
        sorted_q.push_back(r);
      end
      held_cnt  = 0;
      keys_lost = 1'b0;
    end
  endtask

  task automatic push_key(input logic [KeyW-1:0] key, input logic last);
    key_req_t r;
    r.key  = key;
    r.last = last;
    key_feed_q.push_back(r);
  endtask

  // Driver: bursts of requests with random gaps; a stalled request holds still.
  always @(posedge clk_i) begin : driver
    key_req_t        item;
    logic            nxt_valid;
    logic [KeyW-1:0] nxt_key;
    logic            nxt_end;
    nxt_valid = in_valid_i;
    nxt_key   = key_in_i;
    nxt_end   = set_end_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        collect_key(key_in_i, set_end_i);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (key_feed_q.size() > 0) begin
          item      = key_feed_q.pop_front();
          nxt_valid = 1'b1;
          nxt_key   = item.key;
          nxt_end   = item.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    in_valid_i <= nxt_valid;
    key_in_i   <= nxt_key;
    set_end_i  <= nxt_end;
  end

  // Sink: stall pattern switches between modes; one long hold-off fills the engine.
  sink_mode_e sink_mode  = SinkFree;
  int         mode_left  = 0;
  int         sink_clock = 0;
  int         hold_left  = 0;

  always @(posedge clk_i) begin : sink
    logic nxt_stall;
    sink_clock++;
    if (mode_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 200);
    end else begin
      mode_left--;
    end
    if (sink_clock == HoldStart) hold_left = HoldCycles;
    case (sink_mode)
      SinkFree:   nxt_stall = 1'b0;
      SinkLight:  nxt_stall = ($urandom_range(0, 7) == 0);
      SinkHeavy:  nxt_stall = ($urandom_range(0, 1) == 0);
      default:    nxt_stall = ~out_stall_i;
    endcase
    if (hold_left > 0) begin
      nxt_stall = 1'b1;
      hold_left--;
    end
    out_stall_i <= nxt_stall;
  end

  // Monitor: each result against the oldest expectation.
  always @(posedge clk_i) begin : monitor
    sorted_key_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sorted_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: key %h run_end %b dropped %b",
                   key_out_o, run_end_o, dropped_o);
      end else begin
        want = sorted_q.pop_front();
        if (key_out_o !== want.key || run_end_o !== want.run_end ||
            dropped_o !== want.dropped) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: key %h/%h run_end %b/%b dropped %b/%b (expected/actual)",
                     want.key, key_out_o, want.run_end, run_end_o, want.dropped, dropped_o);
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int pick, size, flavor, k;
    logic [KeyW-1:0] key;
    // single-key sets at both extremes
    push_key(16'hFFFF, 1'b1);
    push_key(16'h0000, 1'b1);
    // two keys, both orders
    push_key(16'hFFFF, 1'b0);
    push_key(16'h0000, 1'b1);
    push_key(16'h0000, 1'b0);
    push_key(16'hFFFF, 1'b1);
    // equal keys
    push_key(16'h8000, 1'b0);
    push_key(16'h8000, 1'b0);
    push_key(16'h8000, 1'b1);
    // strictly descending
    for (k = 5; k >= 1; k--) push_key(KeyW'(k), k == 1);
    // alternating bit patterns
    push_key(16'hAAAA, 1'b0);
    push_key(16'h5555, 1'b0);
    push_key(16'h0001, 1'b0);
    push_key(16'hFFFE, 1'b0);
    push_key(16'h8000, 1'b1);

    // random sets: mostly small, some full, some past capacity
    while (key_feed_q.size() < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      size = $urandom_range(1, 12);
      else if (pick < 82) size = $urandom_range(13, 40);
      else if (pick < 90) size = Cap;
      else                size = $urandom_range(Cap + 1, Cap + 6);
      flavor = $urandom_range(0, 3);
      for (k = 0; k < size; k++) begin
        case (flavor)
          0:       key = KeyW'($urandom);
          1:       key = KeyW'($urandom_range(0, 7));
          2:       key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: key = (k % 2) ? KeyW'($urandom_range(0, 15))
                                 : (16'hFFF0 | KeyW'($urandom_range(0, 15)));
        endcase
        push_key(key, k == size - 1);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all requests taken, then all results in, then a quiet tail
    @(negedge clk_i);
    while (key_feed_q.size() > 0 || in_valid_i) @(negedge clk_i);
    while (sorted_q.size() > 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    if (errors == 0) begin
      $display("PASS cocktail_shaker_sort_engine");
    end else begin
      $display("FAIL cocktail_shaker_sort_engine");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL cocktail_shaker_sort_engine");
    $finish;
  end

endmodule
